// ----- sv/sorted_set_table_assert.svh -----
// assertion macros for the sorted set table
`ifndef SORTED_SET_TABLE_ASSERT_SVH
`define SORTED_SET_TABLE_ASSERT_SVH
`ifndef SYNTH
`define SST_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted set table assertion failed");
`define SST_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted set table assertion failed");
`else
`define SST_ASSERT_NOW(label, ante, cons)
`define SST_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- sv/sst_pkg.sv -----
// shared types and constants of the sorted set table
`default_nettype none
package sst_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int KEY_BITS_DEF = 32;
    localparam int KEY_W        = 32;
    localparam int FIELD_W      = 7;

    typedef enum logic [1:0] {
        CMD_ADD      = 2'd0,
        CMD_REMOVE   = 2'd1,
        CMD_CONTAINS = 2'd2
    } command_t;

    typedef struct packed {
        logic [1:0]       command;
        logic [KEY_W-1:0] key;
    } item_t;

    typedef struct packed {
        logic               hit;
        logic [FIELD_W-1:0] position;
        logic [FIELD_W-1:0] count;
        logic               rejected;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROBE,
        ST_COMPARE,
        ST_DECIDE,
        ST_SHIFT,
        ST_FLUSH,
        ST_INSERT,
        ST_FINISH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic probe;
        logic step;
        logic shift_start;
        logic shift_rd;
        logic ins;
        logic finish;
    } ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic search_done;
        logic hit;
        logic is_add;
        logic do_insert;
        logic do_remove;
        logic need_shift;
        logic shift_last;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

// ----- sv/sst_ctrl.sv -----
// sequencing state machine of the sorted set table
`default_nettype none
module sst_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_stall,
    input  wire sst_pkg::status_t stat,
    output sst_pkg::ctrl_t        ctrl
);

    sst_pkg::state_t state_reg;
    sst_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sst_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        item_stall = (state_reg != sst_pkg::ST_IDLE);
        case (state_reg)
            sst_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    ctrl.load  = 1'b1;
                    state_next = sst_pkg::ST_PROBE;
                end
            end
            sst_pkg::ST_PROBE:
            begin
                if (stat.search_done)
                begin
                    state_next = sst_pkg::ST_DECIDE;
                end
                else
                begin
                    ctrl.probe = 1'b1;
                    state_next = sst_pkg::ST_COMPARE;
                end
            end
            sst_pkg::ST_COMPARE:
            begin
                ctrl.step  = 1'b1;
                state_next = sst_pkg::ST_PROBE;
            end
            sst_pkg::ST_DECIDE:
            begin
                if (stat.do_insert || stat.do_remove)
                begin
                    if (stat.need_shift)
                    begin
                        ctrl.shift_start = 1'b1;
                        state_next       = sst_pkg::ST_SHIFT;
                    end
                    else if (stat.do_insert)
                    begin
                        state_next = sst_pkg::ST_INSERT;
                    end
                    else
                    begin
                        state_next = sst_pkg::ST_FINISH;
                    end
                end
                else
                begin
                    state_next = sst_pkg::ST_FINISH;
                end
            end
            sst_pkg::ST_SHIFT:
            begin
                ctrl.shift_rd = 1'b1;
                if (stat.shift_last)
                begin
                    state_next = sst_pkg::ST_FLUSH;
                end
            end
            sst_pkg::ST_FLUSH:
            begin
                // trailing write of the shift lands in this cycle
                state_next = stat.is_add ? sst_pkg::ST_INSERT : sst_pkg::ST_FINISH;
            end
            sst_pkg::ST_INSERT:
            begin
                ctrl.ins   = 1'b1;
                state_next = sst_pkg::ST_FINISH;
            end
            sst_pkg::ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    ctrl.finish = 1'b1;
                    state_next  = sst_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sst_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- sv/sst_datapath.sv -----
// key memory, search bounds, shift pipeline and result register
`default_nettype none
module sst_datapath #(
    parameter int CAPACITY = sst_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = sst_pkg::KEY_BITS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire sst_pkg::item_t   item,
    input  wire sst_pkg::ctrl_t   ctrl,
    output sst_pkg::status_t      stat,
    output sst_pkg::result_t      result,
    output logic                  result_valid,
    input  wire logic             result_stall
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CAPACITY[CNT_W-1:0];
    localparam logic [CNT_W-1:0] ONE_CNT = {{(CNT_W-1){1'b0}}, 1'b1};
    localparam logic [IDX_W-1:0] ONE_IDX = IDX_W'(1);

    logic [KEY_BITS-1:0] entries [CAPACITY];

    logic [KEY_BITS-1:0] key_reg, key_next;
    logic                is_add_reg, is_add_next;
    logic                is_rem_reg, is_rem_next;
    logic [CNT_W-1:0]    lo_reg, lo_next;
    logic [CNT_W-1:0]    hi_reg, hi_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                eq_reg, eq_next;
    logic [IDX_W-1:0]    cursor_reg, cursor_next;
    logic                dir_up_reg, dir_up_next;
    logic                wpend_reg, wpend_next;
    logic [IDX_W-1:0]    waddr_reg, waddr_next;
    logic [KEY_BITS-1:0] rdata_reg;
    sst_pkg::result_t    out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    logic [CNT_W:0]      mid_sum;
    logic [IDX_W-1:0]    mid;
    logic                full;
    logic                do_insert;
    logic                do_remove;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [KEY_BITS-1:0] wr_data;
    logic [CNT_W-1:0]    lo_plus1;

    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid       = IDX_W'(mid_sum >> 1);
    assign full      = (cnt_reg == CAP_CNT);
    assign do_insert = is_add_reg && !eq_reg && !full;
    assign do_remove = is_rem_reg && eq_reg;
    assign lo_plus1  = lo_reg + ONE_CNT;

    always_comb
    begin
        stat.search_done = !(lo_reg < hi_reg);
        stat.hit         = eq_reg;
        stat.is_add      = is_add_reg;
        stat.do_insert   = do_insert;
        stat.do_remove   = do_remove;
        stat.need_shift  = do_insert ? (lo_reg < cnt_reg) : (lo_plus1 < cnt_reg);
        stat.shift_last  = dir_up_reg ? (CNT_W'(cursor_reg) == lo_reg)
                                      : (CNT_W'(cursor_reg) == cnt_reg - ONE_CNT);
        stat.out_free    = !out_valid_reg || !result_stall;
    end

    // memory ports
    assign rd_en   = ctrl.probe || ctrl.shift_rd;
    assign rd_addr = ctrl.probe ? mid : cursor_reg;
    assign wr_en   = wpend_reg || ctrl.ins;
    assign wr_addr = wpend_reg ? waddr_reg : IDX_W'(lo_reg);
    assign wr_data = wpend_reg ? rdata_reg : key_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= entries[rd_addr];
        end
        if (wr_en)
        begin
            entries[wr_addr] <= wr_data;
        end
    end

    always_comb
    begin
        key_next       = key_reg;
        is_add_next    = is_add_reg;
        is_rem_next    = is_rem_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        cnt_next       = cnt_reg;
        eq_next        = eq_reg;
        cursor_next    = cursor_reg;
        dir_up_next    = dir_up_reg;
        wpend_next     = 1'b0;
        waddr_next     = waddr_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && result_stall;

        if (ctrl.load)
        begin
            key_next    = KEY_BITS'(item.key);
            is_add_next = (item.command == sst_pkg::CMD_ADD);
            is_rem_next = (item.command == sst_pkg::CMD_REMOVE);
            lo_next     = '0;
            hi_next     = cnt_reg;
            eq_next     = 1'b0;
        end

        if (ctrl.step)
        begin
            if (rdata_reg < key_reg)
            begin
                lo_next = CNT_W'(mid) + ONE_CNT;
            end
            else
            begin
                // last probe that lowers hi sits at the final lower bound
                hi_next = CNT_W'(mid);
                eq_next = (rdata_reg == key_reg);
            end
        end

        if (ctrl.shift_start)
        begin
            dir_up_next = is_add_reg;
            cursor_next = is_add_reg ? IDX_W'(cnt_reg - ONE_CNT) : IDX_W'(lo_plus1);
        end

        // each read is written one slot over in the following cycle
        if (ctrl.shift_rd)
        begin
            wpend_next  = 1'b1;
            waddr_next  = dir_up_reg ? cursor_reg + ONE_IDX : cursor_reg - ONE_IDX;
            cursor_next = dir_up_reg ? cursor_reg - ONE_IDX : cursor_reg + ONE_IDX;
        end

        if (ctrl.finish)
        begin
            if (do_insert)
            begin
                cnt_next = cnt_reg + ONE_CNT;
            end
            else if (do_remove)
            begin
                cnt_next = cnt_reg - ONE_CNT;
            end
            out_next.hit      = eq_reg;
            out_next.position = sst_pkg::FIELD_W'(lo_reg);
            out_next.count    = sst_pkg::FIELD_W'(cnt_next);
            out_next.rejected = is_add_reg && !eq_reg && full;
            out_valid_next    = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            wpend_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            wpend_reg     <= wpend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        is_add_reg <= is_add_next;
        is_rem_reg <= is_rem_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        eq_reg     <= eq_next;
        cursor_reg <= cursor_next;
        dir_up_reg <= dir_up_next;
        waddr_reg  <= waddr_next;
        out_reg    <= out_next;
    end

    assign result       = out_reg;
    assign result_valid = out_valid_reg;

endmodule
`default_nettype wire

// ----- sv/sorted_set_table.sv -----
// sorted set table: distinct keys kept in ascending unsigned order in a
// single-port-write, single-port-read memory of CAPACITY entries. Each
// transaction (add, remove, contains) yields one result. A lower-bound binary
// search does each probe as a memory read, then a compare, with at most
// ceil(log2(count+1)) probes. An add of a new key then moves the
// count-position larger entries up one slot at one entry per cycle, followed
// by the flush and insert states; a remove moves the count-position-1 later
// entries down likewise, followed by the flush state. The slowest transaction
// is removing the smallest key of a full table; the shift rate is set by the
// one read and one write the key memory allows per cycle. A new transaction
// is taken as soon as the previous result sits in the output register. Reset
// clears the count, pending write, result valid flag and state, so the block
// is ready at once.
`default_nettype none
`include "sorted_set_table_assert.svh"
module sorted_set_table #(
    parameter int CAPACITY = sst_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = sst_pkg::KEY_BITS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_stall,
    input  wire sst_pkg::item_t   item,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output sst_pkg::result_t      result
);

    localparam logic [sst_pkg::FIELD_W-1:0] CAP_FIELD = CAPACITY[sst_pkg::FIELD_W-1:0];

    sst_pkg::ctrl_t   ctrl;
    sst_pkg::status_t stat;

    sst_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .stat       (stat),
        .ctrl       (ctrl)
    );

    sst_datapath #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .ctrl         (ctrl),
        .stat         (stat),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

    // busy right after taking a transaction
    `SST_ASSERT_NEXT(a_busy_after_accept, item_valid && !item_stall, item_stall)
    // key insert write only for an add of a key not yet present
    `SST_ASSERT_NOW(a_insert_new_key, ctrl.ins, stat.is_add && !stat.hit)
    // a rejected add reports a full table
    `SST_ASSERT_NOW(a_reject_full, result_valid && result.rejected, result.count == CAP_FIELD)

endmodule
`default_nettype wire

// ----- tb/sorted_set_table_test.sv -----
// self-checking testbench for the sorted set table: add/remove/contains traffic against a set model
`timescale 1ns / 1ps
`default_nettype none
module sorted_set_table_test;

    localparam int TABLE_DEPTH = sst_pkg::CAPACITY_DEF;
    localparam int KW          = sst_pkg::KEY_W;
    localparam int FW          = sst_pkg::FIELD_W;
    localparam int KEY_POOL    = 100;
    localparam int RANDOM_OPS  = 828;
    localparam int DRAIN_WAIT  = 120;
    localparam logic [1:0] CMD_SPARE = 2'd3;    // undefined opcode, behaves as contains

    localparam logic [KW-1:0] KEY_ZERO = '0;
    localparam logic [KW-1:0] KEY_ONES = '1;
    localparam logic [KW-1:0] KEY_MSB  = {1'b1, {(KW-1){1'b0}}};
    localparam logic [KW-1:0] KEY_MID  = {1'b0, {(KW-1){1'b1}}};

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             item_valid = 1'b0;
    logic             item_stall;
    sst_pkg::item_t   item = '0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    sst_pkg::result_t result;

    // model of the table contents
    logic [KW-1:0] set_keys [TABLE_DEPTH];
    int unsigned   set_size = 0;

    sst_pkg::item_t   ops_to_send [$];
    sst_pkg::result_t predicted_replies [$];
    logic [KW-1:0]    key_pool [KEY_POOL];

    int unsigned errors = 0;
    int unsigned ops_taken = 0;
    int unsigned replies_seen = 0;
    int unsigned hits_seen = 0;
    int unsigned rejects_seen = 0;
    int unsigned peak_size = 0;
    int unsigned send_gap = 0;
    int unsigned send_quiet = 0;
    int unsigned stall_left = 0;
    int unsigned stall_quiet = 0;
    int unsigned gap_now;
    sst_pkg::result_t want;

    sorted_set_table u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // applies one transaction to the model and returns the reply it should produce
    function automatic sst_pkg::result_t apply_set_op(sst_pkg::item_t op);
        int unsigned      lo;
        int unsigned      hi;
        int unsigned      mid;
        int unsigned      i;
        logic             found;
        logic             full_reject;
        sst_pkg::result_t reply;
        lo = 0;
        hi = set_size;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (set_keys[mid] < op.key)
                lo = mid + 1;
            else
                hi = mid;
        end
        found = (lo < set_size) && (set_keys[lo] == op.key);
        full_reject = 1'b0;
        case (op.command)
            sst_pkg::CMD_ADD:
                if (!found)
                begin
                    if (set_size >= TABLE_DEPTH)
                        full_reject = 1'b1;
                    else
                    begin
                        for (i = set_size; i > lo; i--)
                            set_keys[i] = set_keys[i-1];
                        set_keys[lo] = op.key;
                        set_size++;
                    end
                end
            sst_pkg::CMD_REMOVE:
                if (found)
                begin
                    for (i = lo; i + 1 < set_size; i++)
                        set_keys[i] = set_keys[i+1];
                    set_size--;
                end
            default: ;
        endcase
        reply.hit      = found;
        reply.position = lo[FW-1:0];
        reply.count    = set_size[FW-1:0];
        reply.rejected = full_reject;
        return reply;
    endfunction

    // idle length: mostly none or short, a few long, with occasional quiet stretches
    function automatic int unsigned idle_len(inout int unsigned quiet);
        int unsigned r;
        if (quiet > 0)
        begin
            quiet--;
            return 0;
        end
        r = $urandom_range(0, 199);
        if (r == 0)
        begin
            quiet = $urandom_range(30, 80);
            return 0;
        end
        if (r < 80)
            return 0;
        if (r < 170)
            return $urandom_range(1, 3);
        if (r < 194)
            return $urandom_range(4, 15);
        return $urandom_range(40, 120);
    endfunction

    task automatic queue_op(logic [1:0] command, logic [KW-1:0] key);
        sst_pkg::item_t op;
        op.command = command;
        op.key     = key;
        ops_to_send.push_back(op);
    endtask

    function automatic logic [KW-1:0] pick_key();
        if ($urandom_range(0, 99) < 78)
            return key_pool[$urandom_range(0, KEY_POOL-1)];
        return $urandom();
    endfunction

    // sender: holds a stalled transaction, otherwise waits out its gap then offers the next
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
            send_gap   <= 0;
        end
        else
        begin
            gap_now = send_gap;
            if (item_valid && !item_stall)
            begin
                predicted_replies.push_back(apply_set_op(item));
                ops_taken++;
                gap_now = idle_len(send_quiet);
            end
            if (item_valid && item_stall)
            begin
                // payload and valid stay put
            end
            else if (gap_now > 0)
            begin
                item_valid <= 1'b0;
                send_gap   <= gap_now - 1;
            end
            else if (ops_to_send.size() != 0)
            begin
                item       <= ops_to_send.pop_front();
                item_valid <= 1'b1;
                send_gap   <= 0;
            end
            else
            begin
                item_valid <= 1'b0;
                send_gap   <= 0;
            end
        end
    end

    // receiver back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left   <= 0;
        end
        else if (stall_left > 0)
        begin
            result_stall <= 1'b1;
            stall_left   <= stall_left - 1;
        end
        else
        begin
            result_stall <= 1'b0;
            if ($urandom_range(0, 3) == 0)
                stall_left <= idle_len(stall_quiet);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            replies_seen++;
            if (predicted_replies.size() == 0)
            begin
                $error("result with no transaction outstanding: %p", result);
                errors++;
            end
            else
            begin
                want = predicted_replies.pop_front();
                if (result.hit != want.hit)
                begin
                    $error("hit: expected %0d, got %0d", want.hit, result.hit);
                    errors++;
                end
                if (result.position != want.position)
                begin
                    $error("position: expected %0d, got %0d", want.position, result.position);
                    errors++;
                end
                if (result.count != want.count)
                begin
                    $error("count: expected %0d, got %0d", want.count, result.count);
                    errors++;
                end
                if (result.rejected != want.rejected)
                begin
                    $error("rejected: expected %0d, got %0d", want.rejected, result.rejected);
                    errors++;
                end
                if (want.hit)
                    hits_seen++;
                if (want.rejected)
                    rejects_seen++;
                if (want.count > peak_size)
                    peak_size = want.count;
            end
        end
    end

    initial
    begin
        int unsigned made;
        int unsigned span;
        int unsigned bias;
        int unsigned r;
        int unsigned add_w;
        int unsigned rem_w;
        int unsigned n;
        int unsigned total;
        logic [1:0]  cmd;

        for (n = 0; n < KEY_POOL; n++)
            key_pool[n] = $urandom();
        key_pool[0] = KEY_ZERO;
        key_pool[1] = KEY_ONES;
        key_pool[2] = KEY_MSB;
        key_pool[3] = KEY_MID;
        key_pool[4] = KEY_ZERO + 1;
        key_pool[5] = KEY_ONES - 1;

        // directed: extremes, duplicates, misses, the spare opcode, emptying the table
        queue_op(sst_pkg::CMD_ADD, KEY_ZERO);
        queue_op(sst_pkg::CMD_ADD, KEY_ONES);
        queue_op(sst_pkg::CMD_ADD, KEY_ZERO);
        queue_op(sst_pkg::CMD_CONTAINS, KEY_ZERO);
        queue_op(sst_pkg::CMD_CONTAINS, KEY_ONES);
        queue_op(sst_pkg::CMD_CONTAINS, 32'd5);
        queue_op(CMD_SPARE, KEY_ONES);
        queue_op(CMD_SPARE, 32'd7);
        queue_op(sst_pkg::CMD_REMOVE, 32'd7);
        queue_op(sst_pkg::CMD_ADD, KEY_MSB);
        queue_op(sst_pkg::CMD_ADD, KEY_MID);
        queue_op(sst_pkg::CMD_ADD, KEY_ZERO + 1);
        queue_op(sst_pkg::CMD_REMOVE, KEY_ONES);
        queue_op(sst_pkg::CMD_REMOVE, KEY_ZERO);
        queue_op(sst_pkg::CMD_CONTAINS, KEY_MSB);
        queue_op(sst_pkg::CMD_REMOVE, KEY_ZERO + 1);
        queue_op(sst_pkg::CMD_REMOVE, KEY_MID);
        queue_op(sst_pkg::CMD_REMOVE, KEY_MSB);
        queue_op(sst_pkg::CMD_REMOVE, KEY_ZERO);
        queue_op(sst_pkg::CMD_CONTAINS, KEY_ZERO);
        queue_op(sst_pkg::CMD_ADD, 32'hAAAA_AAAA);
        queue_op(sst_pkg::CMD_ADD, 32'h5555_5555);

        // random phases; the first one is add-heavy and long so the table fills up
        made = 0;
        bias = 0;
        while (made < RANDOM_OPS)
        begin
            span = (made == 0) ? 140 : $urandom_range(40, 120);
            if (span > RANDOM_OPS - made)
                span = RANDOM_OPS - made;
            case (bias)
                0:
                begin
                    add_w = 70;
                    rem_w = 15;
                end
                1:
                begin
                    add_w = 15;
                    rem_w = 70;
                end
                default:
                begin
                    add_w = 35;
                    rem_w = 35;
                end
            endcase
            for (n = 0; n < span; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < add_w)
                    cmd = sst_pkg::CMD_ADD;
                else if (r < add_w + rem_w)
                    cmd = sst_pkg::CMD_REMOVE;
                else if (r < 96)
                    cmd = sst_pkg::CMD_CONTAINS;
                else
                    cmd = CMD_SPARE;
                queue_op(cmd, pick_key());
            end
            made += span;
            // rotate part of the pool so fresh key bits keep appearing
            for (n = 0; n < 8; n++)
                key_pool[$urandom_range(6, KEY_POOL-1)] = $urandom();
            bias = $urandom_range(0, 2);
        end
        total = ops_to_send.size();

        @(posedge rst_n);
        while (replies_seen < total)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (replies_seen != total || predicted_replies.size() != 0 || ops_taken != total)
        begin
            $error("sent %0d, taken %0d, replies %0d, still predicted %0d",
                   total, ops_taken, replies_seen, predicted_replies.size());
            errors++;
        end

        $display("ran %0d transactions, %0d replies checked: %0d hits, %0d full-table rejects",
                 ops_taken, replies_seen, hits_seen, rejects_seen);
        $display("largest table occupancy reached: %0d of %0d", peak_size, TABLE_DEPTH);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #(20_000_000);
        $display("timeout with %0d replies outstanding", predicted_replies.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
`default_nettype wire
